// File: src/npc_pkg.sv
`default_nettype none
package npc_pkg;

  localparam int DIV_STEPS = 32;

  localparam logic [1:0] CFG_NEAR_PLANE = 2'd0;
  localparam logic [1:0] CFG_X_SCALE    = 2'd1;
  localparam logic [1:0] CFG_Y_SCALE    = 2'd2;

  localparam logic signed [31:0] Q16_ONE  = 32'sd65536;
  localparam logic [31:0]        SAT_POS  = 32'h7FFF_FFFF;
  localparam logic [31:0]        SAT_NEG  = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by_coord;
    logic signed [31:0] bz;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sx_kept;
    logic signed [31:0] sy_kept;
    logic signed [31:0] sx_other;
    logic signed [31:0] sy_other;
    logic               was_clipped;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] near_plane;
    logic [31:0]        x_scale;
    logic [31:0]        y_scale;
  } cfg_t;

  // Moved endpoint (mv) and the endpoint that stays (st), with offset signs.
  typedef struct packed {
    logic               valid;
    logic               clipped;
    logic               neg_x;
    logic               neg_y;
    logic signed [31:0] mv_x;
    logic signed [31:0] mv_y;
    logic signed [31:0] mv_z;
    logic signed [31:0] st_x;
    logic signed [31:0] st_y;
    logic signed [31:0] st_z;
  } clip_side_t;

  typedef struct packed {
    logic valid;
    logic clipped;
    logic neg_kx;
    logic neg_ky;
    logic neg_ox;
    logic neg_oy;
  } proj_side_t;

  typedef struct packed {
    logic [63:0] work;
    logic [31:0] dvs;
    logic        ovf;
  } div_stage_t;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  function automatic div_stage_t div_step(div_stage_t s);
    logic [32:0] top;
    logic [32:0] diff;
    logic        qb;
    div_stage_t  r;
    top  = s.work[63:31];
    diff = top - {1'b0, s.dvs};
    qb   = (top >= {1'b0, s.dvs});
    r    = s;
    r.work = {(qb ? diff[31:0] : top[31:0]), s.work[30:0], qb};
    return r;
  endfunction

  function automatic logic [31:0] sat_q(logic [31:0] q, logic ovf, logic neg);
    logic [31:0] r;
    if (neg) begin
      if (ovf || (q > SAT_NEG)) r = SAT_NEG;
      else r = 32'd0 - q;
    end else begin
      if (ovf || (q > SAT_POS)) r = SAT_POS;
      else r = q;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/near_plane_clip_project_line.sv
// Throughput: one segment per cycle while the skid register is empty; two banks of
// 32-step pipelined dividers (clip, then projection) set the depth. Segments with
// both endpoints in front yield no request.
// Reset: near_plane, x_scale and y_scale return to 1.0 (Q16.16), the pipeline and
// output skid empty. Configuration writes are taken every cycle.
`default_nettype none
module near_plane_clip_project_line (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire npc_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output npc_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  npc_pkg::cfg_t       cfg;
  logic                adv;
  npc_pkg::clip_side_t side5;
  logic [63:0]         prod_x, prod_y;
  logic [31:0]         den;
  logic [31:0]         qx, qy;
  logic                ovf_cx, ovf_cy;
  npc_pkg::clip_side_t cdl [npc_pkg::DIV_STEPS];
  npc_pkg::proj_side_t pside8;
  npc_pkg::proj_side_t pdl [npc_pkg::DIV_STEPS];
  logic [63:0]         pkx, pky, pox, poy;
  logic [31:0]         mzk, mzo;
  logic [31:0]         qkx, qky, qox, qoy;
  logic                fkx, fky, fox, foy;

  assign cfg_ready = 1'b1;
  assign in_ready  = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.near_plane <= npc_pkg::Q16_ONE;
      cfg.x_scale    <= 32'(npc_pkg::Q16_ONE);
      cfg.y_scale    <= 32'(npc_pkg::Q16_ONE);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        npc_pkg::CFG_NEAR_PLANE: cfg.near_plane <= $signed(cfg_data);
        npc_pkg::CFG_X_SCALE:    cfg.x_scale    <= cfg_data;
        npc_pkg::CFG_Y_SCALE:    cfg.y_scale    <= cfg_data;
        default: ;
      endcase
    end
  end

  npc_clip u_clip (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .near_plane (cfg.near_plane),
    .side       (side5),
    .prod_x     (prod_x),
    .prod_y     (prod_y),
    .den        (den)
  );

  npc_div u_div_cx (.clk(clk), .en(adv), .dividend(prod_x), .divisor(den),
                    .quo(qx), .ovf(ovf_cx));
  npc_div u_div_cy (.clk(clk), .en(adv), .dividend(prod_y), .divisor(den),
                    .quo(qy), .ovf(ovf_cy));

  // Carry the segment alongside the clip dividers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < npc_pkg::DIV_STEPS; j++) cdl[j].valid <= 1'b0;
    end else if (adv) begin
      cdl[0] <= side5;
      for (int j = 1; j < npc_pkg::DIV_STEPS; j++) cdl[j] <= cdl[j-1];
    end
  end

  npc_proj u_proj (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .side  (cdl[npc_pkg::DIV_STEPS-1]),
    .qx    (qx),
    .qy    (qy),
    .cfg   (cfg),
    .pside (pside8),
    .pkx   (pkx),
    .pky   (pky),
    .pox   (pox),
    .poy   (poy),
    .mzk   (mzk),
    .mzo   (mzo)
  );

  npc_div u_div_kx (.clk(clk), .en(adv), .dividend(pkx), .divisor(mzk),
                    .quo(qkx), .ovf(fkx));
  npc_div u_div_ky (.clk(clk), .en(adv), .dividend(pky), .divisor(mzk),
                    .quo(qky), .ovf(fky));
  npc_div u_div_ox (.clk(clk), .en(adv), .dividend(pox), .divisor(mzo),
                    .quo(qox), .ovf(fox));
  npc_div u_div_oy (.clk(clk), .en(adv), .dividend(poy), .divisor(mzo),
                    .quo(qoy), .ovf(foy));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < npc_pkg::DIV_STEPS; j++) pdl[j].valid <= 1'b0;
    end else if (adv) begin
      pdl[0] <= pside8;
      for (int j = 1; j < npc_pkg::DIV_STEPS; j++) pdl[j] <= pdl[j-1];
    end
  end

  npc_out u_out (
    .clk       (clk),
    .rst       (rst),
    .pside     (pdl[npc_pkg::DIV_STEPS-1]),
    .qkx       (qkx),
    .qky       (qky),
    .qox       (qox),
    .qoy       (qoy),
    .fkx       (fkx),
    .fky       (fky),
    .fox       (fox),
    .foy       (foy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .adv       (adv)
  );

  a_clip_fits: assert property (@(posedge clk) disable iff (rst)
    cdl[npc_pkg::DIV_STEPS-1].valid && cdl[npc_pkg::DIV_STEPS-1].clipped
      |-> !ovf_cx && !ovf_cy)
    else $error("clip offset quotient overflowed");

  a_stall_has_output: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending output request");

endmodule
`default_nettype wire

// File: src/npc_div.sv
`default_nettype none
module npc_div (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic [31:0]      quo,
  output logic             ovf
);

  npc_pkg::div_stage_t st [npc_pkg::DIV_STEPS];
  npc_pkg::div_stage_t first;

  // Quotient must fit 32 bits; flag it when the upper half already reaches the divisor.
  always_comb begin
    first.work = dividend;
    first.dvs  = divisor;
    first.ovf  = (dividend[63:32] >= divisor);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= npc_pkg::div_step(first);
      for (int j = 1; j < npc_pkg::DIV_STEPS; j++) begin
        st[j] <= npc_pkg::div_step(st[j-1]);
      end
    end
  end

  assign quo = st[npc_pkg::DIV_STEPS-1].work[31:0];
  assign ovf = st[npc_pkg::DIV_STEPS-1].ovf;

endmodule
`default_nettype wire

// File: src/npc_clip.sv
`default_nettype none
module npc_clip (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               adv,
  input  wire logic               in_valid,
  input  wire npc_pkg::in_item_t  in_data,
  input  wire logic signed [31:0] near_plane,
  output npc_pkg::clip_side_t     side,
  output logic [63:0]             prod_x,
  output logic [63:0]             prod_y,
  output logic [31:0]             den
);

  typedef struct packed {
    logic               valid;
    logic               clipped;
    logic signed [31:0] mv_x;
    logic signed [31:0] mv_y;
    logic signed [31:0] mv_z;
    logic signed [31:0] st_x;
    logic signed [31:0] st_y;
    logic signed [31:0] st_z;
  } sel_t;

  logic              v1;
  npc_pkg::in_item_t it1;
  sel_t              s2;
  sel_t              s2_next;
  sel_t              s3;
  logic signed [32:0] dx3, dy3;
  logic [31:0]       num3, den3;
  sel_t              s4;
  logic [31:0]       mx4, my4, num4, den4;
  logic              nx4, ny4;
  logic              af, bf;
  logic [32:0]       ndx, ndy;

  always_comb begin
    af = ($signed(it1.az) < near_plane);
    bf = ($signed(it1.bz) < near_plane);
    s2_next.valid   = v1 && !(af && bf);
    s2_next.clipped = af ^ bf;
    // Drop the endpoint in front of the plane into the moved slot.
    if (af) begin
      s2_next.mv_x = it1.ax; s2_next.mv_y = it1.ay;       s2_next.mv_z = it1.az;
      s2_next.st_x = it1.bx; s2_next.st_y = it1.by_coord; s2_next.st_z = it1.bz;
    end else begin
      s2_next.mv_x = it1.bx; s2_next.mv_y = it1.by_coord; s2_next.mv_z = it1.bz;
      s2_next.st_x = it1.ax; s2_next.st_y = it1.ay;       s2_next.st_z = it1.az;
    end
  end

  assign ndx = 33'd0 - dx3;
  assign ndy = 33'd0 - dy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      s2.valid   <= 1'b0;
      s3.valid   <= 1'b0;
      s4.valid   <= 1'b0;
      side.valid <= 1'b0;
    end else if (adv) begin
      v1   <= in_valid;
      it1  <= in_data;
      s2   <= s2_next;
      s3   <= s2;
      dx3  <= $signed({s2.st_x[31], s2.st_x}) - $signed({s2.mv_x[31], s2.mv_x});
      dy3  <= $signed({s2.st_y[31], s2.st_y}) - $signed({s2.mv_y[31], s2.mv_y});
      num3 <= near_plane - s2.mv_z;
      den3 <= s2.st_z - s2.mv_z;
      s4   <= s3;
      mx4  <= dx3[32] ? ndx[31:0] : dx3[31:0];
      my4  <= dy3[32] ? ndy[31:0] : dy3[31:0];
      nx4  <= dx3[32];
      ny4  <= dy3[32];
      num4 <= num3;
      den4 <= den3;
      side.valid   <= s4.valid;
      side.clipped <= s4.clipped;
      side.neg_x   <= nx4;
      side.neg_y   <= ny4;
      side.mv_x    <= s4.mv_x;
      side.mv_y    <= s4.mv_y;
      side.mv_z    <= s4.mv_z;
      side.st_x    <= s4.st_x;
      side.st_y    <= s4.st_y;
      side.st_z    <= s4.st_z;
      prod_x <= {32'd0, mx4} * {32'd0, num4};
      prod_y <= {32'd0, my4} * {32'd0, num4};
      den    <= den4;
    end
  end

endmodule
`default_nettype wire

// File: src/npc_proj.sv
`default_nettype none
module npc_proj (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                adv,
  input  wire npc_pkg::clip_side_t side,
  input  wire logic [31:0]         qx,
  input  wire logic [31:0]         qy,
  input  wire npc_pkg::cfg_t       cfg,
  output npc_pkg::proj_side_t      pside,
  output logic [63:0]              pkx,
  output logic [63:0]              pky,
  output logic [63:0]              pox,
  output logic [63:0]              poy,
  output logic [31:0]              mzk,
  output logic [31:0]              mzo
);

  typedef struct packed {
    logic               valid;
    logic               clipped;
    logic signed [31:0] k_x;
    logic signed [31:0] k_y;
    logic signed [31:0] k_z;
    logic signed [31:0] o_x;
    logic signed [31:0] o_y;
    logic signed [31:0] o_z;
  } pt_t;

  typedef struct packed {
    logic        valid;
    logic        clipped;
    logic        nkx, nky, nox, noy;
    logic [31:0] mkx, mky, mox, moy, mzk, mzo;
  } mag_t;

  pt_t  p6, p6_next;
  mag_t m7, m7_next;
  logic [32:0] sx, sy;
  logic signed [31:0] ezk, ezo;

  function automatic logic signed [31:0] eff_depth(logic signed [31:0] z,
                                                   logic signed [31:0] np);
    logic signed [31:0] e;
    e = (z < np) ? np : z;
    if (e == 32'sd0) e = npc_pkg::Q16_ONE;
    return e;
  endfunction

  function automatic logic [31:0] abs32(logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  always_comb begin
    sx = side.neg_x ? ({side.mv_x[31], side.mv_x} - {1'b0, qx})
                    : ({side.mv_x[31], side.mv_x} + {1'b0, qx});
    sy = side.neg_y ? ({side.mv_y[31], side.mv_y} - {1'b0, qy})
                    : ({side.mv_y[31], side.mv_y} + {1'b0, qy});
    p6_next.valid   = side.valid;
    p6_next.clipped = side.clipped;
    p6_next.k_x     = side.st_x;
    p6_next.k_y     = side.st_y;
    p6_next.k_z     = side.st_z;
    // The moved point lies between the endpoints, so 32 bits hold it.
    p6_next.o_x     = side.clipped ? sx[31:0] : side.mv_x;
    p6_next.o_y     = side.clipped ? sy[31:0] : side.mv_y;
    p6_next.o_z     = side.clipped ? cfg.near_plane : side.mv_z;
  end

  always_comb begin
    ezk = eff_depth(p6.k_z, cfg.near_plane);
    ezo = eff_depth(p6.o_z, cfg.near_plane);
    m7_next.valid   = p6.valid;
    m7_next.clipped = p6.clipped;
    m7_next.nkx = p6.k_x[31] ^ ezk[31];
    m7_next.nky = p6.k_y[31] ^ ezk[31];
    m7_next.nox = p6.o_x[31] ^ ezo[31];
    m7_next.noy = p6.o_y[31] ^ ezo[31];
    m7_next.mkx = abs32(p6.k_x);
    m7_next.mky = abs32(p6.k_y);
    m7_next.mox = abs32(p6.o_x);
    m7_next.moy = abs32(p6.o_y);
    m7_next.mzk = abs32(ezk);
    m7_next.mzo = abs32(ezo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p6.valid    <= 1'b0;
      m7.valid    <= 1'b0;
      pside.valid <= 1'b0;
    end else if (adv) begin
      p6 <= p6_next;
      m7 <= m7_next;
      pside.valid   <= m7.valid;
      pside.clipped <= m7.clipped;
      pside.neg_kx  <= m7.nkx;
      pside.neg_ky  <= m7.nky;
      pside.neg_ox  <= m7.nox;
      pside.neg_oy  <= m7.noy;
      pkx <= {32'd0, m7.mkx} * {32'd0, cfg.x_scale};
      pky <= {32'd0, m7.mky} * {32'd0, cfg.y_scale};
      pox <= {32'd0, m7.mox} * {32'd0, cfg.x_scale};
      poy <= {32'd0, m7.moy} * {32'd0, cfg.y_scale};
      mzk <= m7.mzk;
      mzo <= m7.mzo;
    end
  end

endmodule
`default_nettype wire

// File: src/npc_out.sv
`default_nettype none
module npc_out (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire npc_pkg::proj_side_t pside,
  input  wire logic [31:0]         qkx,
  input  wire logic [31:0]         qky,
  input  wire logic [31:0]         qox,
  input  wire logic [31:0]         qoy,
  input  wire logic                fkx,
  input  wire logic                fky,
  input  wire logic                fox,
  input  wire logic                foy,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output npc_pkg::out_item_t       out_data,
  output logic                     adv
);

  npc_pkg::out_item_t item;
  npc_pkg::out_item_t skid_data;
  logic               skid_valid;

  always_comb begin
    item.sx_kept     = $signed(npc_pkg::sat_q(qkx, fkx, pside.neg_kx));
    item.sy_kept     = $signed(npc_pkg::sat_q(qky, fky, pside.neg_ky));
    item.sx_other    = $signed(npc_pkg::sat_q(qox, fox, pside.neg_ox));
    item.sy_other    = $signed(npc_pkg::sat_q(qoy, foy, pside.neg_oy));
    item.was_clipped = pside.clipped;
  end

  // The pipeline moves only while the skid register is free.
  assign adv = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!skid_valid) begin
      if (!out_valid || out_ready) begin
        out_valid <= pside.valid;
        out_data  <= item;
      end else if (pside.valid) begin
        skid_valid <= 1'b1;
        skid_data  <= item;
      end
    end else if (out_ready) begin
      out_data   <= skid_data;
      skid_valid <= 1'b0;
    end
  end

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid filled without a stalled request");

  a_skid_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a request while output is empty");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_ready |=> !skid_valid)
    else $error("skid did not drain");

endmodule
`default_nettype wire

// File: tb/npc_line_checker.sv
module npc_line_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire npc_pkg::in_item_t  in_data,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire npc_pkg::out_item_t out_data,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  output int                      fail_count,
  output int                      pending
);

  logic signed [31:0]  near_q;
  logic [31:0]         xs_q;
  logic [31:0]         ys_q;
  npc_pkg::out_item_t  screen_q[$];

  // coord * scale / depth, truncated toward zero, then saturated
  function automatic logic [31:0] screen_coord(logic signed [63:0] c, logic [31:0] sc,
                                               logic signed [63:0] z);
    logic         neg;
    logic [63:0]  mc, mz, q, r;
    logic [127:0] hi, tot;
    neg = (c < 0) != (z < 0);
    mc  = (c < 0) ? -c : c;
    mz  = (z < 0) ? -z : z;
    q   = mc / mz;
    r   = mc % mz;
    if (q >= 64'h1_0000_0000) begin
      tot = (sc != 0) ? 128'h2_0000_0000 : 128'd0;
    end else begin
      hi = {64'd0, q} * {96'd0, sc};
      if (hi > 128'h1_0000_0000) tot = 128'h2_0000_0000;
      else tot = hi + ({64'd0, r} * {96'd0, sc}) / {64'd0, mz};
    end
    if (!neg) begin
      if (tot > {96'd0, npc_pkg::SAT_POS}) tot = {96'd0, npc_pkg::SAT_POS};
      return tot[31:0];
    end
    if (tot > {96'd0, npc_pkg::SAT_NEG}) tot = {96'd0, npc_pkg::SAT_NEG};
    return 32'd0 - tot[31:0];
  endfunction

  // slide c1 toward c2 by num/den, offset truncated toward zero
  function automatic logic signed [63:0] slide_coord(logic signed [63:0] c1,
      logic signed [63:0] c2, logic [63:0] num, logic [63:0] den);
    logic signed [63:0] d;
    logic [63:0]        m;
    logic [127:0]       off;
    d   = c2 - c1;
    m   = (d < 0) ? -d : d;
    off = ({64'd0, m} * {64'd0, num}) / {64'd0, den};
    return (d < 0) ? c1 - $signed(off[63:0]) : c1 + $signed(off[63:0]);
  endfunction

  function automatic logic signed [63:0] clamp_depth(logic signed [63:0] z,
                                                     logic signed [63:0] np);
    logic signed [63:0] e;
    e = (z < np) ? np : z;
    return (e == 0) ? 64'sd65536 : e;
  endfunction

  function automatic bit project_segment(npc_pkg::in_item_t s,
                                         output npc_pkg::out_item_t res);
    logic signed [63:0] np, ax, ay, az, bx, by, bz;
    logic signed [63:0] kx, ky, kz, ox, oy, oz, zk, zo;
    logic               af, bf;
    np = near_q; ax = s.ax; ay = s.ay; az = s.az;
    bx = s.bx; by = s.by_coord; bz = s.bz;
    af = az < np;
    bf = bz < np;
    res = '0;
    if (af && bf) return 0;
    if (af) begin
      kx = bx; ky = by; kz = bz;
      ox = slide_coord(ax, bx, np - az, bz - az);
      oy = slide_coord(ay, by, np - az, bz - az);
      oz = np;
    end else if (bf) begin
      kx = ax; ky = ay; kz = az;
      ox = slide_coord(bx, ax, np - bz, az - bz);
      oy = slide_coord(by, ay, np - bz, az - bz);
      oz = np;
    end else begin
      kx = ax; ky = ay; kz = az; ox = bx; oy = by; oz = bz;
    end
    zk = clamp_depth(kz, np);
    zo = clamp_depth(oz, np);
    res.sx_kept     = screen_coord(kx, xs_q, zk);
    res.sy_kept     = screen_coord(ky, ys_q, zk);
    res.sx_other    = screen_coord(ox, xs_q, zo);
    res.sy_other    = screen_coord(oy, ys_q, zo);
    res.was_clipped = af || bf;
    return 1;
  endfunction

  assign pending = screen_q.size();

  always @(posedge clk) begin
    npc_pkg::out_item_t exp_item;
    npc_pkg::out_item_t pred;
    int                 errs;
    errs = 0;
    if (rst) begin
      near_q <= npc_pkg::Q16_ONE;
      xs_q   <= 32'd65536;
      ys_q   <= 32'd65536;
      fail_count <= 0;
      screen_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          npc_pkg::CFG_NEAR_PLANE: near_q <= cfg_data;
          npc_pkg::CFG_X_SCALE:    xs_q   <= cfg_data;
          npc_pkg::CFG_Y_SCALE:    ys_q   <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (project_segment(in_data, pred)) screen_q.push_back(pred);
      end
      if (out_valid && out_ready) begin
        if (screen_q.size() == 0) begin
          $display("%0t unexpected request: exp none got %h", $time, out_data);
          errs++;
        end else begin
          exp_item = screen_q.pop_front();
          if (exp_item.sx_kept !== out_data.sx_kept) begin
            $display("%0t sx_kept exp %h got %h", $time, exp_item.sx_kept, out_data.sx_kept);
            errs++;
          end
          if (exp_item.sy_kept !== out_data.sy_kept) begin
            $display("%0t sy_kept exp %h got %h", $time, exp_item.sy_kept, out_data.sy_kept);
            errs++;
          end
          if (exp_item.sx_other !== out_data.sx_other) begin
            $display("%0t sx_other exp %h got %h", $time, exp_item.sx_other,
                     out_data.sx_other);
            errs++;
          end
          if (exp_item.sy_other !== out_data.sy_other) begin
            $display("%0t sy_other exp %h got %h", $time, exp_item.sy_other,
                     out_data.sy_other);
            errs++;
          end
          if (exp_item.was_clipped !== out_data.was_clipped) begin
            $display("%0t was_clipped exp %b got %b", $time, exp_item.was_clipped,
                     out_data.was_clipped);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end
endmodule

// File: tb/tb_near_plane_clip_project_line.sv
module tb_near_plane_clip_project_line;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  npc_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  npc_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  int                 fail_count;
  int                 pending;
  logic signed [31:0] cur_near = npc_pkg::Q16_ONE;
  logic               long_hold = 1'b0;

  always #5 clk = ~clk;

  near_plane_clip_project_line u_dut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  npc_line_checker u_chk (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fail_count, .pending
  );

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 90);
  endfunction

  task automatic send_seg(npc_pkg::in_item_t s);
    int gap;
    gap = (cfg_index == npc_pkg::CFG_NEAR_PLANE && $urandom_range(0, 3) == 0) ?
          0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    in_valid  <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
    if (idx == npc_pkg::CFG_NEAR_PLANE) cur_near = val;
  endtask

  // let every dropped segment leave the pipeline before touching registers
  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    wait (pending == 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_view(logic [31:0] np, logic [31:0] xs, logic [31:0] ys);
    drain();
    write_reg(npc_pkg::CFG_NEAR_PLANE, np);
    write_reg(npc_pkg::CFG_X_SCALE, xs);
    write_reg(npc_pkg::CFG_Y_SCALE, ys);
  endtask

  function automatic logic [31:0] pick_depth();
    logic signed [63:0] z;
    case ($urandom_range(0, 5))
      0: z = 64'(cur_near) + $signed(64'($urandom_range(0, 64))) - 32;
      1: z = 64'(cur_near) + $signed(64'($urandom_range(0, 32'h0020_0000))) - 64'h10_0000;
      2: z = 0;
      3: z = 64'(cur_near) + $signed(64'($urandom_range(0, 32'h4000_0000)));
      default: z = $signed($urandom());
    endcase
    if (z > 64'sh7FFF_FFFF) z = 64'sh7FFF_FFFF;
    if (z < -64'sh8000_0000) z = -64'sh8000_0000;
    return z[31:0];
  endfunction

  function automatic logic [31:0] pick_coord();
    if ($urandom_range(0, 2) == 0)
      return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    return $urandom();
  endfunction

  function automatic npc_pkg::in_item_t random_seg();
    npc_pkg::in_item_t s;
    s.ax = pick_coord(); s.ay = pick_coord(); s.az = pick_depth();
    s.bx = pick_coord(); s.by_coord = pick_coord(); s.bz = pick_depth();
    return s;
  endfunction

  task automatic random_run(int n);
    repeat (n) send_seg(random_seg());
  endtask

  // receiver: random stalls, plus one long hold-off to back the pipe up
  initial begin
    int stall;
    bit long_done;
    stall = 0;
    long_done = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold && !long_done) begin
        stall = 400;
        long_done = 1'b1;
      end else if (stall == 0 && $urandom_range(0, 9) == 0) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: neither, a in front, b in front, both in front, zero depth, extremes
    send_seg('{32'sh0001_0000, 32'sh0002_0000, 32'sh0004_0000,
               -32'sh0003_0000, 32'sh0001_8000, 32'sh0008_0000});
    send_seg('{32'sh0005_0000, -32'sh0002_0000, 32'sh0000_4000,
               -32'sh0001_0000, 32'sh0003_0000, 32'sh0010_0000});
    send_seg('{32'sh0002_0000, 32'sh0001_0000, 32'sh0003_0000,
               32'sh0007_0000, -32'sh0004_0000, -32'sh0005_0000});
    send_seg('{32'sh0001_0000, 32'sh0001_0000, 32'sh0000_0000,
               32'sh0001_0000, 32'sh0001_0000, -32'sh0001_0000});
    send_seg('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000,
               32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
    send_seg('{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
               32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF});
    send_seg('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
               32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
    send_seg('{32'sh0000_0000, 32'sh0000_0000, 32'sh0001_0000,
               32'sh0000_0000, 32'sh0000_0000, 32'sh0001_0000});

    // plane at zero, max scales: zero depths become one
    set_view(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_seg('{32'sh0001_0000, -32'sh0001_0000, 32'sh0000_0000,
               32'sh0002_0000, 32'sh0003_0000, 32'sh0000_0000});
    send_seg('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0001,
               32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0001});
    send_seg('{32'sh0004_0000, 32'sh0004_0000, -32'sh0001_0000,
               -32'sh0004_0000, 32'sh0002_0000, 32'sh0002_0000});
    send_seg('{32'sh0004_0000, 32'sh0004_0000, -32'sh0001_0000,
               -32'sh0004_0000, 32'sh0002_0000, -32'sh0002_0000});
    random_run(80);

    // most negative plane, zero scales: nothing lies in front
    set_view(32'h8000_0000, 32'h0, 32'h0);
    send_seg('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
               32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000});
    send_seg('{32'sh1234_5678, -32'sh0765_4321, -32'sh0001_0000,
               32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0000});
    random_run(60);

    // negative plane with mixed scales
    set_view(-32'sh0002_0000, 32'h0001_8000, 32'h0000_8000);
    send_seg('{32'sh0003_0000, 32'sh0003_0000, -32'sh0004_0000,
               -32'sh0001_0000, 32'sh0002_0000, 32'sh0004_0000});
    random_run(80);

    // most positive plane: almost everything dropped
    set_view(32'h7FFF_FFFF, 32'h0001_0000, 32'hFFFF_FFFF);
    send_seg('{32'sh0001_0000, 32'sh0001_0000, 32'sh7FFF_FFFF,
               32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000});
    send_seg('{32'sh0001_0000, 32'sh0001_0000, 32'sh7FFF_FFFF,
               32'sh0002_0000, 32'sh0002_0000, 32'sh7FFF_FFFF});
    random_run(40);

    // hold the receiver off while this run keeps offering requests
    set_view(32'h0000_4000, 32'h0140_0000, 32'h00F0_0000);
    long_hold = 1'b1;
    random_run(100);

    set_view($urandom(), $urandom(), $urandom());
    random_run(80);

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// File: filelist.f
src/npc_pkg.sv
src/npc_div.sv
src/npc_clip.sv
src/npc_proj.sv
src/npc_out.sv
src/near_plane_clip_project_line.sv
tb/npc_line_checker.sv
tb/tb_near_plane_clip_project_line.sv
